>>> rtl/cmtl_pkg.sv
`default_nettype none

package cmtl_pkg;

  localparam int unsigned MaxCellsAcrossDef = 64;
  localparam int unsigned MaxCellSize       = 64;

  localparam int unsigned SumW     = 20;
  localparam int unsigned PosW     = 6;
  localparam int unsigned RegW     = 7;
  localparam int unsigned ThrW     = 8;
  localparam int unsigned GreyW    = 8;
  localparam int unsigned PixW     = 8;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 8;
  localparam int unsigned ProdW    = 2 * RegW;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QPtrW      = 2;

  // Register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] RegCellWidth   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegCellHeight  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegCellsAcross = 3'd2;
  localparam logic [CfgIdxW-1:0] RegCellsDown   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegThreshold   = 3'd4;

  localparam logic [RegW-1:0] CellWidthRst   = 7'd8;
  localparam logic [RegW-1:0] CellHeightRst  = 7'd8;
  localparam logic [RegW-1:0] CellsAcrossRst = 7'd32;
  localparam logic [RegW-1:0] CellsDownRst   = 7'd32;
  localparam logic [ThrW-1:0] ThresholdRst   = 8'd127;

  localparam logic [RegW-1:0] PosLimit  = 7'd64;
  localparam logic [RegW-1:0] SizeLimit =
      RegW'((MaxCellSize < 64) ? MaxCellSize : 64);

  // Effective lattice geometry after clamping
  typedef struct packed {
    logic [RegW-1:0] cw;
    logic [RegW-1:0] ch;
    logic [RegW-1:0] ca;
    logic [RegW-1:0] cd;
  } sizes_t;

  // One classified pixel on its way to the accumulators
  typedef struct packed {
    logic [GreyW-1:0] grey;
    logic [PosW-1:0]  col;
    logic [PosW-1:0]  row;
    logic             first;
    logic             emit;
    logic             frame_end;
  } item_t;

  // Zero acts as one; larger values saturate at the bound
  function automatic logic [RegW-1:0] clamp_size(input logic [RegW-1:0] v,
                                                 input logic [RegW-1:0] lim);
    logic [RegW-1:0] r;
    r = v;
    if (r == '0) begin
      r = RegW'(1);
    end
    if (r > lim) begin
      r = lim;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/cmtl_front.sv
`default_nettype none

module cmtl_front (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      in_valid_i,
  output logic                     in_ready_o,
  input  wire  [7:0]               red_i,
  input  wire  [7:0]               green_i,
  input  wire  [7:0]               blue_i,
  input  wire  cmtl_pkg::sizes_t   sizes_i,
  input  wire                      full_i,
  output logic                     push_o,
  output cmtl_pkg::item_t          item_o
);
  import cmtl_pkg::*;

  localparam int unsigned LumaW = 22;

  logic [PosW-1:0] col_in_q, col_in_d;
  logic [PosW-1:0] col_of_q, col_of_d;
  logic [PosW-1:0] row_in_q, row_in_d;
  logic [PosW-1:0] row_of_q, row_of_d;

  logic [LumaW-1:0] luma;
  logic last_col, last_row, last_cell_col, last_cell_row;

  // BT.601 weights in 14-bit fixed point, rounded half up
  assign luma = LumaW'(red_i)   * LumaW'(4899)
              + LumaW'(green_i) * LumaW'(9617)
              + LumaW'(blue_i)  * LumaW'(1868)
              + LumaW'(8192);

  assign last_col      = ({1'b0, col_in_q} + RegW'(1)) >= sizes_i.cw;
  assign last_row      = ({1'b0, row_in_q} + RegW'(1)) >= sizes_i.ch;
  assign last_cell_col = ({1'b0, col_of_q} + RegW'(1)) >= sizes_i.ca;
  assign last_cell_row = ({1'b0, row_of_q} + RegW'(1)) >= sizes_i.cd;

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

  always_comb begin
    item_o.grey      = luma[LumaW-1 -: GreyW];
    item_o.col       = col_of_q;
    item_o.row       = row_of_q;
    item_o.first     = (col_in_q == '0) && (row_in_q == '0);
    item_o.emit      = last_col && last_row;
    item_o.frame_end = last_cell_col && last_cell_row;
  end

  always_comb begin
    col_in_d = col_in_q;
    col_of_d = col_of_q;
    row_in_d = row_in_q;
    row_of_d = row_of_q;
    if (!last_col) begin
      col_in_d = col_in_q + PosW'(1);
    end else begin
      col_in_d = '0;
      if (!last_cell_col) begin
        col_of_d = col_of_q + PosW'(1);
      end else begin
        col_of_d = '0;
        if (!last_row) begin
          row_in_d = row_in_q + PosW'(1);
        end else begin
          row_in_d = '0;
          row_of_d = last_cell_row ? '0 : row_of_q + PosW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_in_q <= '0;
      col_of_q <= '0;
      row_in_q <= '0;
      row_of_q <= '0;
    end else if (push_o) begin
      col_in_q <= col_in_d;
      col_of_q <= col_of_d;
      row_in_q <= row_in_d;
      row_of_q <= row_of_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/cmtl_queue.sv
`default_nettype none

module cmtl_queue (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                push_i,
  input  wire cmtl_pkg::item_t item_i,
  output logic               full_o,
  output logic               head_valid_o,
  output cmtl_pkg::item_t    head_o,
  input  wire                pop_i
);
  import cmtl_pkg::*;

  item_t             slot_q [QueueDepth];
  logic [QPtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QPtrW:0]    count_q;

  assign full_o       = count_q == (QPtrW + 1)'(QueueDepth);
  assign head_valid_o = count_q != '0;
  assign head_o       = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + (QPtrW + 1)'(1);
        2'b01:   count_q <= count_q - (QPtrW + 1)'(1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/cmtl_back.sv
`default_nettype none

module cmtl_back #(
  parameter int unsigned MAX_CELLS_ACROSS = cmtl_pkg::MaxCellsAcrossDef
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            head_valid_i,
  input  wire  cmtl_pkg::item_t          head_i,
  output logic                           pop_o,
  input  wire  [cmtl_pkg::SumW-1:0]      limit_i,
  output logic                           out_valid_o,
  input  wire                            out_ready_i,
  output logic                           dark_o,
  output logic [5:0]                     cell_col_o,
  output logic [5:0]                     cell_row_o,
  output logic                           frame_end_o
);
  import cmtl_pkg::*;

  localparam int unsigned IdxW = (MAX_CELLS_ACROSS > 1) ? $clog2(MAX_CELLS_ACROSS) : 1;

  logic [SumW-1:0] acc_mem [MAX_CELLS_ACROSS];
  logic [MAX_CELLS_ACROSS-1:0] written_q;

  logic            s2_valid_q;
  item_t           s2_q;
  logic [SumW-1:0] rd_q;
  logic            fwd_hit_q;
  logic [SumW-1:0] fwd_val_q;

  logic            out_valid_q;
  logic            dark_q;
  logic [PosW-1:0] col_q, row_q;
  logic            frame_end_q;

  logic [IdxW-1:0] head_idx, s2_idx;
  logic [SumW-1:0] base, sum;
  logic [SumW:0]   sum_wide;
  logic            s2_fire, out_free;

  assign head_idx = IdxW'(head_i.col);
  assign s2_idx   = IdxW'(s2_q.col);

  // Take the previous write directly when it hit the entry just read
  assign base     = fwd_hit_q ? fwd_val_q : rd_q;
  assign sum_wide = {1'b0, base} + (SumW + 1)'(s2_q.grey);

  always_comb begin
    if (s2_q.first) begin
      sum = SumW'(s2_q.grey);
    end else if (sum_wide[SumW]) begin
      sum = '1;
    end else begin
      sum = sum_wide[SumW-1:0];
    end
  end

  assign out_free = !out_valid_q || out_ready_i;
  assign s2_fire  = s2_valid_q && (!s2_q.emit || out_free);
  assign pop_o    = head_valid_i && (!s2_valid_q || s2_fire);

  always_ff @(posedge clk_i) begin
    if (s2_fire) begin
      acc_mem[s2_idx] <= sum;
    end
    if (pop_o) begin
      rd_q      <= written_q[head_idx] ? acc_mem[head_idx] : '0;
      fwd_val_q <= sum;
      s2_q      <= head_i;
    end
    if (s2_fire && s2_q.emit) begin
      dark_q      <= !(sum > limit_i);
      col_q       <= s2_q.col;
      row_q       <= s2_q.row;
      frame_end_q <= s2_q.frame_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q   <= '0;
      s2_valid_q  <= 1'b0;
      fwd_hit_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s2_fire) begin
        written_q[s2_idx] <= 1'b1;
      end
      if (pop_o) begin
        s2_valid_q <= 1'b1;
        fwd_hit_q  <= s2_fire && (s2_idx == head_idx);
      end else if (s2_fire) begin
        s2_valid_q <= 1'b0;
      end
      if (s2_fire && s2_q.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign dark_o      = dark_q;
  assign cell_col_o  = col_q;
  assign cell_row_o  = row_q;
  assign frame_end_o = frame_end_q;

endmodule

`default_nettype wire

>>> rtl/cell_mean_threshold_lattice.sv
// Cell-average binarizer: one pixel per cycle sustained, one result per finished cell.
// A cell's last pixel passes the pixel queue and the accumulator read register; the add
// and compare then load the cell's result into the output register.
// Throughput: one read and one write of the accumulator memory per cycle; a held result
// stalls the next finished cell, then the four-entry queue fills and drops ready.
// Reset clears position counters, loads register defaults and marks every accumulator
// as zero through per-column flags; no clearing pass, pixels are taken right away.
`default_nettype none

module cell_mean_threshold_lattice #(
  parameter int unsigned MAX_CELLS_ACROSS = cmtl_pkg::MaxCellsAcrossDef
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_we_i,
  input  wire  [cmtl_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  wire  [cmtl_pkg::CfgDataW-1:0]    cfg_data_i,
  input  wire                              in_valid_i,
  output logic                             in_ready_o,
  input  wire  [7:0]                       red_i,
  input  wire  [7:0]                       green_i,
  input  wire  [7:0]                       blue_i,
  output logic                             out_valid_o,
  input  wire                              out_ready_i,
  output logic                             dark_o,
  output logic [5:0]                       cell_col_o,
  output logic [5:0]                       cell_row_o,
  output logic                             frame_end_o
);
  import cmtl_pkg::*;

  localparam logic [RegW-1:0] AcrossLimit =
      RegW'((MAX_CELLS_ACROSS < 64) ? MAX_CELLS_ACROSS : 64);
  localparam logic [ProdW-1:0] ProdRst  = ProdW'(64);
  localparam logic [SumW-1:0]  LimitRst = SumW'(127 * 64);

  logic [RegW-1:0]  cell_width_q, cell_height_q, cells_across_q, cells_down_q;
  logic [ThrW-1:0]  threshold_q;
  logic [ProdW-1:0] area_q;
  logic [SumW-1:0]  limit_q;
  logic [ThrW+ProdW-1:0] limit_full;

  sizes_t sizes;
  item_t  push_item, head_item;
  logic   push, full, head_valid, pop;

  always_comb begin
    sizes.cw = clamp_size(cell_width_q, SizeLimit);
    sizes.ch = clamp_size(cell_height_q, SizeLimit);
    sizes.ca = clamp_size(cells_across_q, AcrossLimit);
    sizes.cd = clamp_size(cells_down_q, PosLimit);
  end

  assign limit_full = (ThrW + ProdW)'(threshold_q) * (ThrW + ProdW)'(area_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_width_q   <= CellWidthRst;
      cell_height_q  <= CellHeightRst;
      cells_across_q <= CellsAcrossRst;
      cells_down_q   <= CellsDownRst;
      threshold_q    <= ThresholdRst;
      area_q         <= ProdRst;
      limit_q        <= LimitRst;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegCellWidth:   cell_width_q   <= cfg_data_i[RegW-1:0];
          RegCellHeight:  cell_height_q  <= cfg_data_i[RegW-1:0];
          RegCellsAcross: cells_across_q <= cfg_data_i[RegW-1:0];
          RegCellsDown:   cells_down_q   <= cfg_data_i[RegW-1:0];
          RegThreshold:   threshold_q    <= cfg_data_i[ThrW-1:0];
          default:        ;
        endcase
      end
      // Compare limit follows a size write via area register, then limit register
      area_q  <= ProdW'(sizes.cw) * ProdW'(sizes.ch);
      limit_q <= limit_full[SumW-1:0];
    end
  end

  cmtl_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .red_i      (red_i),
    .green_i    (green_i),
    .blue_i     (blue_i),
    .sizes_i    (sizes),
    .full_i     (full),
    .push_o     (push),
    .item_o     (push_item)
  );

  cmtl_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .item_i       (push_item),
    .full_o       (full),
    .head_valid_o (head_valid),
    .head_o       (head_item),
    .pop_i        (pop)
  );

  cmtl_back #(
    .MAX_CELLS_ACROSS (MAX_CELLS_ACROSS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head_item),
    .pop_o        (pop),
    .limit_i      (limit_q),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .dark_o       (dark_o),
    .cell_col_o   (cell_col_o),
    .cell_row_o   (cell_row_o),
    .frame_end_o  (frame_end_o)
  );

endmodule

`default_nettype wire
